// ----- hw/rtl/csd_pkg.sv -----
// Shared types and constants for the charlieplexed 5x5 scan display driver.
// No dependencies; used by csd_state, csd_scan and the top level.
package csd_pkg;

	localparam int NUM_ROWS   = 5;
	localparam int ROW_W      = 5;
	localparam int NUM_GROUPS = 6;
	localparam int NUM_LINES  = 6;
	localparam int GROUP_W    = 3;
	localparam int LINE_F     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic {
		KIND_SHIFT = 1'b0,
		KIND_TICK  = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWITCH_SENSE = 1'b0,
		REG_INVERT_TOP   = 1'b1
	} cfg_reg_t;

	typedef logic [NUM_ROWS-1:0][ROW_W-1:0] rows_t;

	typedef struct packed {
		kind_t            kind;
		logic [ROW_W-1:0] column_bits;
		logic             switch_low;
	} item_t;

	typedef struct packed {
		logic [NUM_LINES-1:0] line_enable;
		logic [NUM_LINES-1:0] line_level;
		logic [GROUP_W-1:0]   group_shown;
		logic                 button_event;
	} result_t;

	// state update computed by the scan logic for one tick
	typedef struct packed {
		logic [GROUP_W-1:0] group_next;
		logic               pressed_next;
	} tick_upd_t;

endpackage

// ----- hw/rtl/csd_scan.sv -----
// Combinational scan mapping: picks the lit pixels of the current group and
// drives the six lines; also reports the press edge. Uses csd_pkg.
module csd_scan (
	input  csd_pkg::item_t                  item,
	input  csd_pkg::rows_t                  rows,
	input  logic [csd_pkg::GROUP_W-1:0]     group_q,
	input  logic                            last_pressed_q,
	input  logic                            sense_en,
	input  logic                            invert_top,
	output csd_pkg::result_t                result,
	output csd_pkg::tick_upd_t              upd
);

	always_comb begin
		logic [csd_pkg::GROUP_W-1:0]   g;
		logic [csd_pkg::GROUP_W-1:0]   common;
		logic [csd_pkg::GROUP_W-1:0]   row;
		logic [csd_pkg::NUM_LINES-1:0] enable;
		logic [csd_pkg::NUM_LINES-1:0] level;
		logic                          blank;
		logic                          event_bit;

		// out-of-range counter behaves as group 0
		g = (group_q >= csd_pkg::GROUP_W'(csd_pkg::NUM_GROUPS)) ? '0 : group_q;
		common = csd_pkg::GROUP_W'(csd_pkg::LINE_F) - g;
		enable = '0;
		level = '0;
		row = '0;
		blank = sense_en && item.switch_low;
		event_bit = sense_en && !last_pressed_q && item.switch_low;

		for (int lo = 0; lo < csd_pkg::NUM_ROWS; lo++) begin
			if (csd_pkg::GROUP_W'(lo) != common) begin
				row = (csd_pkg::GROUP_W'(lo) < common) ? g : g - 1'b1;
				if (row < csd_pkg::GROUP_W'(csd_pkg::NUM_ROWS) && rows[row][lo])
					enable[lo] = 1'b1;
			end
		end

		// common line drives only when some pixel of the group is lit
		if (blank || enable == '0) begin
			enable = '0;
		end else begin
			enable[common] = 1'b1;
			if (!(common == csd_pkg::GROUP_W'(csd_pkg::LINE_F) && invert_top))
				level[common] = 1'b1;
		end

		upd.group_next = (g == csd_pkg::GROUP_W'(csd_pkg::NUM_GROUPS - 1)) ? '0 : g + 1'b1;
		upd.pressed_next = sense_en ? item.switch_low : last_pressed_q;

		if (item.kind == csd_pkg::KIND_TICK) begin
			result.line_enable  = enable;
			result.line_level   = level;
			result.group_shown  = g;
			result.button_event = event_bit;
		end else begin
			result = '0;
		end
	end

endmodule

// ----- hw/rtl/csd_state.sv -----
// Display state: five row registers, group counter, last switch level and the
// two configuration bits. Uses csd_pkg.
module csd_state (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             update,
	input  csd_pkg::item_t                   item,
	input  csd_pkg::tick_upd_t               upd,
	input  logic                             cfg_we,
	input  logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output csd_pkg::rows_t                   rows,
	output logic [csd_pkg::GROUP_W-1:0]      group_q,
	output logic                             last_pressed_q,
	output logic                             sense_en_q,
	output logic                             invert_top_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows <= '0;
			group_q <= '0;
			last_pressed_q <= 1'b0;
		end else if (update) begin
			if (item.kind == csd_pkg::KIND_SHIFT) begin
				// shift left, new pixel enters the rightmost column
				for (int i = 0; i < csd_pkg::NUM_ROWS; i++)
					rows[i] <= {rows[i][csd_pkg::ROW_W-2:0], item.column_bits[i]};
			end else begin
				group_q <= upd.group_next;
				last_pressed_q <= upd.pressed_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_en_q <= 1'b0;
			invert_top_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (csd_pkg::cfg_reg_t'(cfg_index))
				csd_pkg::REG_SWITCH_SENSE: sense_en_q <= cfg_data[0];
				csd_pkg::REG_INVERT_TOP:   invert_top_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/charlieplex_scroll_display_driver_top.sv -----
// Charlieplexed 5x5 scroll display driver. Takes one item (column shift or scan
// tick) per clock while in_stall is low and returns one result for each item,
// which passes the input register, the combinational scan logic and the result
// register in that order; throughput is one item per cycle while out_stall is low.
// Row and group state is read and updated as an item leaves the input register,
// so back-to-back items see each other. Depends on csd_pkg, csd_state and csd_scan.
module charlieplex_scroll_display_driver_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [csd_pkg::ROW_W-1:0]           column_bits,
	input  logic                                switch_low,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [csd_pkg::NUM_LINES-1:0]       line_enable,
	output logic [csd_pkg::NUM_LINES-1:0]       line_level,
	output logic [csd_pkg::GROUP_W-1:0]         group_shown,
	output logic                                button_event,
	input  logic                                cfg_we,
	input  logic [csd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [csd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                        valid_s1;
	csd_pkg::item_t              item_s1;
	logic                        out_valid_q;
	csd_pkg::result_t            result_q;
	logic                        advance;
	csd_pkg::rows_t              rows;
	logic [csd_pkg::GROUP_W-1:0] group_q;
	logic                        last_pressed_q;
	logic                        sense_en_q;
	logic                        invert_top_q;
	csd_pkg::result_t            result;
	csd_pkg::tick_upd_t          upd;

	// item moves from the input register into the result register
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind <= csd_pkg::kind_t'(kind);
			item_s1.column_bits <= column_bits;
			item_s1.switch_low <= switch_low;
		end
	end

	csd_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.update         (advance),
		.item           (item_s1),
		.upd            (upd),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rows           (rows),
		.group_q        (group_q),
		.last_pressed_q (last_pressed_q),
		.sense_en_q     (sense_en_q),
		.invert_top_q   (invert_top_q)
	);

	csd_scan u_scan (
		.item           (item_s1),
		.rows           (rows),
		.group_q        (group_q),
		.last_pressed_q (last_pressed_q),
		.sense_en       (sense_en_q),
		.invert_top     (invert_top_q),
		.result         (result),
		.upd            (upd)
	);

	// hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign line_enable  = result_q.line_enable;
	assign line_level   = result_q.line_level;
	assign group_shown  = result_q.group_shown;
	assign button_event = result_q.button_event;

endmodule
